/* rtl/core/fpfa_pkg.sv */
// ----------------------------------------------------------------------------
// Fixed-partition fit allocator package
// Shared widths, codes and types for the allocator core.
// ----------------------------------------------------------------------------
package fpfa_pkg;

    localparam int PARTITIONS = 64;
    localparam int SIZE_BITS  = 32;
    localparam int SLOT_W     = $clog2(PARTITIONS);
    localparam int CNT_W      = $clog2(PARTITIONS + 1);
    localparam int AMOUNT_W   = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    // Fit policies; the fourth code grants nothing.
    localparam logic [1:0] MODE_FIRST = 2'd0;
    localparam logic [1:0] MODE_BEST  = 2'd1;
    localparam logic [1:0] MODE_WORST = 2'd2;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_REQUEST = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PART_USE  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } fsm_state_t;

    typedef struct packed {
        logic [1:0]       mode;
        logic [CNT_W-1:0] limit;
    } cfg_t;

    typedef struct packed {
        logic                 re;
        logic [SLOT_W-1:0]    raddr;
        logic                 we;
        logic [SLOT_W-1:0]    waddr;
        logic [SIZE_BITS-1:0] wdata;
    } ram_req_t;

endpackage

/* rtl/core/fpfa_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module fpfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/fpfa_ctrl.sv */
// ----------------------------------------------------------------------------
// Allocator sequencer
// Takes items, scans the size table one entry per cycle and writes back the
// cleared size of the granted partition.
// ----------------------------------------------------------------------------
module fpfa_ctrl
    import fpfa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 action,
    input  logic [SLOT_W-1:0]    slot,
    input  logic [AMOUNT_W-1:0]  amount,
    input  logic                 end_of_batch,
    input  cfg_t                 cfg,
    output logic                 busy,
    output logic                 done,
    output logic                 granted,
    output logic [SLOT_W-1:0]    chosen_slot,
    output logic                 batch_done,
    output ram_req_t             ram_req,
    input  logic [SIZE_BITS-1:0] ram_rdata
);

    fsm_state_t state_reg, state_next;

    logic [SIZE_BITS-1:0]  amount_reg;
    logic                  eob_reg;
    logic [1:0]            mode_reg;
    logic [CNT_W-1:0]      lim_reg;
    logic [SLOT_W-1:0]     issue_idx_reg;
    logic [SLOT_W-1:0]     cmp_idx_reg;
    logic                  cmp_valid_reg;
    logic                  vld_q_reg;
    logic [PARTITIONS-1:0] valid_reg;
    logic                  found_reg;
    logic [SLOT_W-1:0]     pick_reg;
    logic [SIZE_BITS-1:0]  best_reg;
    logic                  done_reg;
    logic                  granted_reg;
    logic [SLOT_W-1:0]     chosen_reg;
    logic                  batch_reg;

    logic                  accept;
    logic                  req_accept;
    logic                  skip_scan;
    logic                  last_issue;
    logic [SIZE_BITS-1:0]  cand;
    logic                  take;

    assign accept     = start && (state_reg == ST_IDLE);
    assign req_accept = accept && (action == ACT_REQUEST);
    // An unused mode or an empty search range goes straight to the result.
    assign skip_scan  = (cfg.mode != MODE_FIRST && cfg.mode != MODE_BEST
                         && cfg.mode != MODE_WORST) || (cfg.limit == '0);
    assign last_issue = ({1'b0, issue_idx_reg} == lim_reg - CNT_W'(1));

    // Entries never loaded since reset read as size zero.
    assign cand = vld_q_reg ? ram_rdata : '0;
    assign take = cmp_valid_reg && (cand >= amount_reg) &&
                  (!found_reg ||
                   (mode_reg == MODE_BEST  && cand < best_reg) ||
                   (mode_reg == MODE_WORST && cand > best_reg));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    state_next = skip_scan ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_FINISH;
            ST_FINISH: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy          = (state_reg != ST_IDLE);
        ram_req.re    = (state_reg == ST_SCAN);
        ram_req.raddr = issue_idx_reg;
        ram_req.we    = 1'b0;
        ram_req.waddr = slot;
        ram_req.wdata = amount[SIZE_BITS-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                ram_req.we = accept && (action == ACT_LOAD);
            end
            ST_FINISH:
            begin
                ram_req.we    = found_reg;
                ram_req.waddr = pick_reg;
                ram_req.wdata = '0;
            end
            default:
            begin
                ram_req.we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_valid_reg <= (state_reg == ST_SCAN);
            done_reg      <= (state_reg == ST_FINISH);
            if (accept && (action == ACT_LOAD))
            begin
                valid_reg[slot] <= 1'b1;
            end
            if (req_accept)
            begin
                found_reg <= 1'b0;
            end
            else if (take)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            amount_reg    <= amount[SIZE_BITS-1:0];
            eob_reg       <= end_of_batch;
            mode_reg      <= cfg.mode;
            lim_reg       <= cfg.limit;
            issue_idx_reg <= '0;
        end
        else if (state_reg == ST_SCAN)
        begin
            issue_idx_reg <= issue_idx_reg + SLOT_W'(1);
        end
        cmp_idx_reg <= issue_idx_reg;
        vld_q_reg   <= valid_reg[issue_idx_reg];
        if (take)
        begin
            pick_reg <= cmp_idx_reg;
            best_reg <= cand;
        end
        if (state_reg == ST_FINISH)
        begin
            granted_reg <= found_reg;
            chosen_reg  <= found_reg ? pick_reg : '0;
            batch_reg   <= eob_reg;
        end
    end

    assign done        = done_reg;
    assign granted     = granted_reg;
    assign chosen_slot = chosen_reg;
    assign batch_done  = batch_reg;

`ifndef SYNTH
    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_FINISH))
        else $error("result strobe without a finished search");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_req.we && ram_req.re))
        else $error("table written during a scan");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> ({1'b0, issue_idx_reg} < lim_reg))
        else $error("scan address beyond the search range");

    a_cmp_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_valid_reg |-> $past(ram_req.re))
        else $error("compare without a preceding table read");
`endif

endmodule

/* rtl/core/fixed_partition_fit_allocator.sv */
// ----------------------------------------------------------------------------
// Fixed-partition fit allocator
// Keeps a table of partition sizes and grants requests by first, best or
// worst fit.
//
// Channel   Direction  Handshake              Payload
// item      in         start & !busy          action, slot, amount, end_of_batch
// result    out        done (one cycle)       granted, chosen_slot, batch_done
// config    in         cfg_valid & cfg_ready  cfg_index, cfg_data
//
// A load gives no result. A request scans the table one entry per cycle
// through the single read port, over the first partitions_in_use entries
// with the count capped at the table depth; busy stays high through the
// scan, drain and finish states (only the finish state with an unused mode
// or with no partitions in use), and the result strobe is high in the first
// cycle with busy low. Reset clears all sizes to zero through per-entry
// valid bits, without writing the table. Results cannot be stalled.
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator
    import fpfa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  action,
    input  logic [SLOT_W-1:0]     slot,
    input  logic [AMOUNT_W-1:0]   amount,
    input  logic                  end_of_batch,
    output logic                  done,
    output logic                  granted,
    output logic [SLOT_W-1:0]     chosen_slot,
    output logic                  batch_done,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [1:0]            mode_reg;
    logic [CFG_DATA_W-1:0] part_use_reg;
    cfg_t                  cfg;
    ram_req_t              ram_req;
    logic [SIZE_BITS-1:0]  ram_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_FIRST;
            part_use_reg <= CFG_DATA_W'(PARTITIONS);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FIT_MODE: mode_reg     <= cfg_data[1:0];
                CFG_PART_USE: part_use_reg <= cfg_data;
                default:      mode_reg     <= mode_reg;
            endcase
        end
    end

    // The search range saturates at the table depth.
    always_comb
    begin
        cfg.mode  = mode_reg;
        cfg.limit = (CNT_W'(part_use_reg) > CNT_W'(PARTITIONS)) ?
                    CNT_W'(PARTITIONS) : CNT_W'(part_use_reg);
    end

    fpfa_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .action       (action),
        .slot         (slot),
        .amount       (amount),
        .end_of_batch (end_of_batch),
        .cfg          (cfg),
        .busy         (busy),
        .done         (done),
        .granted      (granted),
        .chosen_slot  (chosen_slot),
        .batch_done   (batch_done),
        .ram_req      (ram_req),
        .ram_rdata    (ram_rdata)
    );

    fpfa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (PARTITIONS)
    ) u_size_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

endmodule
